// ===== hdl/mqsb_pkg.sv =====
// Shared types and constants of the multi-queue shared-buffer unit.
package mqsb_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned QUEUES  = 4;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned PTR_W   = $clog2(ENTRIES + 1);
  localparam int unsigned QID_W   = 2;
  localparam int unsigned DATA_W  = 32;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(ENTRIES);

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                    kind;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] pop_value;
  } rsp_t;

  function automatic logic is_entry(input logic [PTR_W-1:0] p);
    return p < NULL_PTR;
  endfunction

endpackage

// ===== hdl/mqsb_in_reg.sv =====
// Input request register of the multi-queue shared-buffer unit.
module mqsb_in_reg
  import mqsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic req_valid_o,
  input  logic req_take_i,
  output req_t req_o
);

  logic valid_q;
  req_t req_q;

  // Refill while the held request leaves in the same cycle.
  assign in_ready_o  = !valid_q || req_take_i;
  assign req_valid_o = valid_q;
  assign req_o       = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

endmodule

// ===== hdl/mqsb_core.sv =====
// Queue pointers, link store, data store and result register.
module mqsb_core
  import mqsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic req_take_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  logic [PTR_W-1:0]  link_q [ENTRIES];
  logic [PTR_W-1:0]  head_q [QUEUES];
  logic [PTR_W-1:0]  head_d [QUEUES];
  logic [PTR_W-1:0]  tail_q [QUEUES];
  logic [PTR_W-1:0]  tail_d [QUEUES];
  logic [PTR_W-1:0]  free_q, free_d;
  logic [DATA_W-1:0] data_mem [ENTRIES];

  logic              rsp_valid_q;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] pop_value_q;

  logic [PTR_W-1:0]  head, tail, link_rd;
  logic [IDX_W-1:0]  rd_addr;
  logic              q_ok, push_ok, pop_ok;
  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [PTR_W-1:0]  link_wd;

  assign req_take_o  = req_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = '{status: status_q, pop_value: pop_value_q};

  assign q_ok    = {1'b0, req_i.queue_id} < (QID_W + 1)'(QUEUES);
  assign head    = head_q[req_i.queue_id];
  assign tail    = tail_q[req_i.queue_id];
  assign push_ok = q_ok && (req_i.kind == KIND_PUSH) && is_entry(free_q);
  assign pop_ok  = q_ok && (req_i.kind == KIND_POP) && is_entry(head);

  // One link read per request: free-list successor on push, next head on pop.
  assign rd_addr = (req_i.kind == KIND_PUSH) ? free_q[IDX_W-1:0] : head[IDX_W-1:0];
  assign link_rd = link_q[rd_addr];

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    free_d   = free_q;
    link_we  = 1'b0;
    link_wa  = free_q[IDX_W-1:0];
    link_wd  = free_q;
    status_d = ST_OK;
    if (req_i.kind == KIND_PUSH) begin
      if (!push_ok) begin
        status_d = ST_FULL;
      end else begin
        free_d = is_entry(link_rd) ? link_rd : NULL_PTR;
        if (!is_entry(head)) begin
          head_d[req_i.queue_id] = free_q;
        end else if (is_entry(tail)) begin
          link_we = 1'b1;
          link_wa = tail[IDX_W-1:0];
        end
        tail_d[req_i.queue_id] = free_q;
      end
    end else begin
      if (!pop_ok) begin
        status_d = ST_EMPTY;
      end else begin
        // The tail entry carries a stale link; drain the queue on it.
        head_d[req_i.queue_id] = ((head == tail) || !is_entry(link_rd)) ? NULL_PTR : link_rd;
        link_we = 1'b1;
        link_wa = head[IDX_W-1:0];
        link_wd = free_q;
        free_d  = head;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        link_q[i] <= PTR_W'(i + 1);
      end
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NULL_PTR;
        tail_q[i] <= NULL_PTR;
      end
      free_q      <= '0;
      rsp_valid_q <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      if (req_take_o) begin
        head_q   <= head_d;
        tail_q   <= tail_d;
        free_q   <= free_d;
        status_q <= status_d;
        if (link_we) begin
          link_q[link_wa] <= link_wd;
        end
      end
      if (req_take_o) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Data store: write on push, registered read on pop into the result.
  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      if (push_ok) begin
        data_mem[free_q[IDX_W-1:0]] <= req_i.push_value;
      end
      pop_value_q <= pop_ok ? data_mem[head[IDX_W-1:0]] : '0;
    end
  end

endmodule

// ===== hdl/multi_queue_shared_buffer_unit.sv =====
// Top level of the multi-queue shared-buffer unit.
// Path: an accepted request passes the input register, then the result register,
// before its result is offered on the master side; a stall there holds both.
// Throughput: one request per cycle while the master side takes each result.
// Reset: asynchronous, active low; all queues empty, every entry on the free list.
// Data store contents are undefined until written.
module multi_queue_shared_buffer_unit
  import mqsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [1:0] queue_id, [33:2] push_value, rest zero
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] pop_value
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  req_t in_req, req;
  rsp_t rsp;
  logic req_valid, req_take;

  // Unpack the incoming request.
  assign in_req.kind       = kind_e'(s_axis_tuser_i);
  assign in_req.queue_id   = s_axis_tdata_i[QID_W-1:0];
  assign in_req.push_value = s_axis_tdata_i[QID_W +: DATA_W];

  // Hold one request ahead of the queue logic.
  mqsb_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (in_req),
    .req_valid_o (req_valid),
    .req_take_i  (req_take),
    .req_o       (req)
  );

  // Advance pointers and stores, and register the result.
  mqsb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_take_o  (req_take),
    .rsp_valid_o (m_axis_tvalid_o),
    .rsp_ready_i (m_axis_tready_i),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata_o = rsp.pop_value;
  assign m_axis_tuser_o = rsp.status;

endmodule

// ===== bench/multi_queue_shared_buffer_unit_test.sv =====
// Self-checking bench for the multi-queue shared-buffer unit: directed and random push/pop traffic.
module multi_queue_shared_buffer_unit_test;
  import mqsb_pkg::*;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned DRAIN_LIMIT  = 5_000;
  localparam int unsigned SETTLE       = 8;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i  = '0;    // [1:0] queue_id, [33:2] push_value, rest zero
  logic        s_axis_tuser_i  = 1'b0;  // [0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;          // [31:0] pop_value
  logic [1:0]  m_axis_tuser_o;          // [1:0] status

  multi_queue_shared_buffer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
  end

  // Shadow copy of the linked store: data words, links, queue ends and free-list head.
  logic [DATA_W-1:0] shadow_word [ENTRIES];
  logic [PTR_W-1:0]  shadow_link [ENTRIES];
  logic [PTR_W-1:0]  shadow_head [QUEUES];
  logic [PTR_W-1:0]  shadow_tail [QUEUES];
  logic [PTR_W-1:0]  shadow_free;

  rsp_t awaited_replies [$];
  int   fail_count;

  // Idle controls of the request sender and of the result sink.
  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold_cycles;

  function automatic void clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_word[i] = '0;
      shadow_link[i] = PTR_W'(i + 1);
    end
    shadow_link[ENTRIES-1] = NULL_PTR;
    for (int q = 0; q < QUEUES; q++) begin
      shadow_head[q] = NULL_PTR;
      shadow_tail[q] = NULL_PTR;
    end
    shadow_free = '0;
  endfunction

  // Apply one accepted request to the shadow store and return the result it owes.
  function automatic rsp_t apply_queue_op(kind_e op, logic [QID_W-1:0] q,
                                          logic [DATA_W-1:0] word);
    rsp_t             r;
    logic [IDX_W-1:0] slot;
    r.status    = ST_OK;
    r.pop_value = '0;
    if (op == KIND_PUSH) begin
      if (int'(q) >= QUEUES || shadow_free >= NULL_PTR) begin
        r.status = ST_FULL;
      end else begin
        slot        = shadow_free[IDX_W-1:0];
        shadow_free = (shadow_link[slot] < NULL_PTR) ? shadow_link[slot] : NULL_PTR;
        // An empty queue takes the entry as both ends; a stale tail is ignored.
        if (shadow_head[q] >= NULL_PTR)
          shadow_head[q] = PTR_W'(slot);
        else if (shadow_tail[q] < NULL_PTR)
          shadow_link[shadow_tail[q][IDX_W-1:0]] = PTR_W'(slot);
        shadow_link[slot] = NULL_PTR;
        shadow_tail[q]    = PTR_W'(slot);
        shadow_word[slot] = word;
      end
    end else begin
      if (int'(q) >= QUEUES || shadow_head[q] >= NULL_PTR) begin
        r.status = ST_EMPTY;
      end else begin
        slot              = shadow_head[q][IDX_W-1:0];
        shadow_head[q]    = (shadow_link[slot] < NULL_PTR) ? shadow_link[slot] : NULL_PTR;
        shadow_link[slot] = shadow_free;
        shadow_free       = PTR_W'(slot);
        r.pop_value       = shadow_word[slot];
      end
    end
    return r;
  endfunction

  // Record each accepted request first, then check each accepted result in order.
  always @(posedge clk_i) begin : track_traffic
    rsp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        awaited_replies.push_back(apply_queue_op(kind_e'(s_axis_tuser_i),
                                                 s_axis_tdata_i[1:0],
                                                 s_axis_tdata_i[33:2]));
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("unexpected result: status %0d pop_value %h",
                 m_axis_tuser_o, m_axis_tdata_o);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (m_axis_tuser_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
            fail_count++;
          end
          if (m_axis_tdata_o !== want.pop_value) begin
            $error("pop_value: expected %h, got %h", want.pop_value, m_axis_tdata_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Result sink: a long hold-off wins, then random stall bursts, else ready.
  int sink_gap;
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      m_axis_tready_i  <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else if (sink_gap > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_gap        <= sink_gap - 1;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      sink_gap        <= $urandom_range(1, 11) - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Offer one request and hold it until the unit takes it.
  task automatic send_request(input kind_e op, input logic [QID_W-1:0] q,
                              input logic [DATA_W-1:0] word);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'b0, word, q};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic release_sender();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Drop the request line and wait until every owed result has come back.
  task automatic wait_drained();
    int waited;
    release_sender();
    waited = 0;
    while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      $error("%0d results never arrived", awaited_replies.size());
      fail_count++;
      awaited_replies.delete();
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Pop every queue while all are empty.
  task automatic test_pop_empty();
    for (int q = 0; q < QUEUES; q++)
      send_request(KIND_POP, QID_W'(q), $urandom);
  endtask

  // Push extreme words onto each queue, then read them back.
  task automatic test_extreme_words();
    send_request(KIND_PUSH, 2'd0, 32'h8000_0000);
    send_request(KIND_PUSH, 2'd3, 32'h7FFF_FFFF);
    send_request(KIND_PUSH, 2'd1, 32'h0000_0000);
    send_request(KIND_PUSH, 2'd2, 32'hFFFF_FFFF);
    send_request(KIND_POP,  2'd2, 32'h5555_5555);
    send_request(KIND_POP,  2'd0, 32'hAAAA_AAAA);
    send_request(KIND_POP,  2'd3, 32'h0);
    send_request(KIND_POP,  2'd1, 32'hFFFF_FFFF);
  endtask

  // Drain a queue to empty, then refill it so a stale tail must be ignored.
  task automatic test_drain_refill();
    send_request(KIND_PUSH, 2'd1, 32'h1234_5678);
    send_request(KIND_POP,  2'd1, 32'h0);
    send_request(KIND_PUSH, 2'd1, 32'hCAFE_0001);
    send_request(KIND_PUSH, 2'd1, 32'hCAFE_0002);
    send_request(KIND_POP,  2'd1, 32'h0);
    send_request(KIND_POP,  2'd1, 32'h0);
  endtask

  // Hold the sink off long enough that the unit stalls; the pushes behind the stall overflow the store.
  task automatic test_full_under_backpressure();
    @(posedge clk_i);
    sink_hold_cycles = 200;
    for (int i = 0; i < ENTRIES; i++)
      send_request(KIND_PUSH, QID_W'(i % QUEUES), pick_word());
    for (int i = 0; i < 3; i++)
      send_request(KIND_PUSH, QID_W'($urandom_range(0, QUEUES - 1)), pick_word());
    for (int q = 0; q < QUEUES; q++)
      for (int i = 0; i <= ENTRIES / QUEUES; i++)
        send_request(KIND_POP, QID_W'(q), $urandom);
  endtask

  // Random push/pop traffic in phases that lean toward filling, draining or neither.
  task automatic test_random_traffic(input int count);
    int    push_pct;
    int    hot_queue;
    kind_e op;
    logic [QID_W-1:0] q;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
        hot_queue = $urandom_range(0, QUEUES - 1);
      end
      op = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
      q  = ($urandom_range(0, 2) == 0) ? QID_W'(hot_queue)
                                       : QID_W'($urandom_range(0, QUEUES - 1));
      send_request(op, q, pick_word());
    end
  endtask

  initial begin
    LIMIT_GUARD: begin
      #(CLK_PERIOD * LIMIT_CYCLES);
      $display("FAIL multi_queue_shared_buffer_unit");
      $finish;
    end
  end

  initial begin
    fail_count       = 0;
    sink_hold_cycles = 0;
    sink_gap         = 0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    clear_shadow();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pop_empty();
    test_extreme_words();
    test_drain_refill();
    wait_drained();

    test_full_under_backpressure();
    wait_drained();

    test_random_traffic(1450);

    // Close with back-to-back traffic and an always-ready sink.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_traffic(200);
    wait_drained();

    if (fail_count == 0) begin
      $display("PASS multi_queue_shared_buffer_unit");
    end else begin
      $display("FAIL multi_queue_shared_buffer_unit");
    end
    $finish;
  end

endmodule
